[design/dense_single_source_shortest_path_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dense shortest path block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH
`define DENSE_SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dssp_pkg.sv]
// ----------------------------------------------------------------------------
// Dense shortest path package
// Widths, codes, defaults and shared types of the shortest path block.
// ----------------------------------------------------------------------------
package dssp_pkg;

    // Parameter defaults.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int VERTEX_BITS    = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int DIST_BITS      = 24;
    localparam int COUNT_BITS     = 7;
    localparam int OUT_LIMIT      = 64;

    // Configuration port.
    localparam int CFG_DATA_BITS  = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT_VERTEX  = 1'b1;

    // Reset values of the registers.
    localparam logic [COUNT_BITS-1:0]  VERTEX_COUNT_RST = 7'd64;
    localparam logic [VERTEX_BITS-1:0] ROOT_VERTEX_RST  = 6'd0;

    // All-ones distance stands for infinity.
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    // Result of relaxing one vertex.
    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 candidate;
    } t_relax;

endpackage

[design/dssp_in_if.sv]
// ----------------------------------------------------------------------------
// Weight entry channel
// Carries one weight matrix entry per transaction.
// ----------------------------------------------------------------------------
interface dssp_in_if
    import dssp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [VERTEX_BITS-1:0]    row;
    logic [VERTEX_BITS-1:0]    column;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic                      last_entry;

    modport source (output valid, row, column, weight, last_entry, input ready);
    modport sink   (input valid, row, column, weight, last_entry, output ready);
endinterface

[design/dssp_out_if.sv]
// ----------------------------------------------------------------------------
// Distance result channel
// Carries one vertex distance per transaction.
// ----------------------------------------------------------------------------
interface dssp_out_if
    import dssp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [VERTEX_BITS-1:0] vertex;
    logic [DIST_BITS-1:0]   distance;
    logic                   reachable;
    logic                   last_result;

    modport source (output valid, vertex, distance, reachable, last_result, input ready);
    modport sink   (input valid, vertex, distance, reachable, last_result, output ready);
endinterface

[design/dssp_relax.sv]
// ----------------------------------------------------------------------------
// Edge relaxation unit
// Saturating add of the settled distance and an edge weight, then the
// minimum against the stored tentative distance.
// ----------------------------------------------------------------------------
module dssp_relax
    import dssp_pkg::*;
#(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic [DIST_BITS-1:0]   i_best,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [DIST_BITS-1:0]   i_old,
    input  logic                   i_settled,
    output t_relax                 o_res
);
    localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

    logic [SUM_BITS-1:0]  sum;
    logic [DIST_BITS-1:0] sat;

    // Sum saturates to infinity.
    assign sum = SUM_BITS'(i_best) + SUM_BITS'(i_weight);
    assign sat = (sum > SUM_BITS'(DIST_INF)) ? DIST_INF : sum[DIST_BITS-1:0];

    // Settled vertices keep their distance and are no candidates.
    always_comb begin
        o_res.distance  = i_old;
        o_res.candidate = !i_settled;
        if (!i_settled && (i_weight != NO_EDGE) && (sat < i_old)) begin
            o_res.distance = sat;
        end
    end
endmodule

[design/dense_single_source_shortest_path.sv]
// Loading: one weight entry per cycle, each written to the weight memory as it is accepted.
// Solving: an initialization pass over the distance memory, then up to n rounds,
// each a one-read-per-cycle sweep of the weight and distance memories, a drain and a pick.
// Output: one result at a time, read, captured and held until the sink takes it; results in vertex order.
// Synchronous active-low reset clears the control state and settled flags and
// sets vertex_count to 64 and root_vertex to 0; the weight store is not cleared.
// ----------------------------------------------------------------------------
// Dense single-source shortest path
// Stores an adjacency matrix and runs Dijkstra from the root vertex, one
// relaxation per cycle through the distance memory, then emits distances.
// ----------------------------------------------------------------------------
module dense_single_source_shortest_path
    import dssp_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    dssp_in_if.sink                   i_item,
    dssp_out_if.source                o_result
);
    localparam int CAP   = (MAX_VERTICES < OUT_LIMIT) ? MAX_VERTICES : OUT_LIMIT;
    localparam int VW    = $clog2(CAP);
    localparam int AW    = $clog2(CAP * CAP);
    localparam logic [COUNT_BITS-1:0] CAP_C = COUNT_BITS'(CAP);

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_SWEEP, S_DRAIN, S_PICK, S_ORD, S_OCAP, S_OWAIT
    } t_state;

    // Control registers.
    t_state                 r_state, n_state;
    logic [COUNT_BITS-1:0]  r_vcount, n_vcount;
    logic [VERTEX_BITS-1:0] r_root, n_root;
    logic [CAP-1:0]         r_settled, n_settled;
    logic                   r_p_vld, n_p_vld;
    logic                   r_o_valid, n_o_valid;

    // Payload registers.
    logic [VW-1:0]          r_n_last, n_n_last;
    logic [VW-1:0]          r_v, n_v;
    logic [VW-1:0]          r_u, n_u;
    logic [VW-1:0]          r_p_v, n_p_v;
    logic [VW-1:0]          r_arg, n_arg;
    logic [DIST_BITS-1:0]   r_best, n_best;
    logic [DIST_BITS-1:0]   r_min, n_min;
    logic [VERTEX_BITS-1:0] r_o_vertex, n_o_vertex;
    logic [DIST_BITS-1:0]   r_o_dist, n_o_dist;
    logic                   r_o_reach, n_o_reach;
    logic                   r_o_last, n_o_last;

    // Memories and their registered read data.
    logic [WEIGHT_BITS-1:0] r_wmem [CAP*CAP];
    logic [WEIGHT_BITS-1:0] r_wrd;
    logic [DIST_BITS-1:0]   r_dmem [CAP];
    logic [DIST_BITS-1:0]   r_drd;

    logic                   in_fire;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic                   d_we;
    logic [VW-1:0]          d_waddr;
    logic [DIST_BITS-1:0]   d_wdata;
    logic [COUNT_BITS-1:0]  n_used;
    logic [COUNT_BITS-1:0]  n_used_last;
    logic                   root_ok;
    logic [VW-1:0]          root_idx;
    t_relax                 relax;

    assign i_item.ready = (r_state == S_LOAD);
    assign in_fire      = i_item.valid && i_item.ready;

    assign o_result.valid       = r_o_valid;
    assign o_result.vertex      = r_o_vertex;
    assign o_result.distance    = r_o_dist;
    assign o_result.reachable   = r_o_reach;
    assign o_result.last_result = r_o_last;

    // Vertex count in use, saturated to the supported range.
    assign n_used = (r_vcount == '0) ? COUNT_BITS'(1) :
                    ((r_vcount > CAP_C) ? CAP_C : r_vcount);
    assign n_used_last = n_used - COUNT_BITS'(1);

    // The root takes part only when it lies below the vertex count.
    assign root_ok  = (COUNT_BITS'(r_root) <= COUNT_BITS'(r_n_last));
    assign root_idx = r_root[VW-1:0];

    // Weight memory addressing.
    assign w_we = in_fire && (COUNT_BITS'(i_item.row) < CAP_C)
                          && (COUNT_BITS'(i_item.column) < CAP_C);
    assign w_waddr = AW'(i_item.row[VW-1:0]) * AW'(CAP) + AW'(i_item.column[VW-1:0]);
    assign w_raddr = AW'(r_u) * AW'(CAP) + AW'(r_v);

    // Distance memory write: initialization pass or relaxation stage.
    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_p_v;
        d_wdata = relax.distance;
        if (r_state == S_INIT) begin
            d_we    = 1'b1;
            d_waddr = r_v;
            d_wdata = (root_ok && (COUNT_BITS'(r_v) == COUNT_BITS'(r_root))) ?
                      '0 : DIST_INF;
        end else if (r_p_vld) begin
            d_we = 1'b1;
        end
    end

    // Weight memory: written while loading, read every cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= WEIGHT_BITS'(i_item.weight);
        end
        r_wrd <= r_wmem[w_raddr];
    end

    // Distance memory: read every cycle at the current vertex index.
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        r_drd <= r_dmem[r_v];
    end

    // Relaxation of the vertex read in the previous cycle.
    dssp_relax #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .i_best    (r_best),
        .i_weight  (r_wrd),
        .i_old     (r_drd),
        .i_settled (r_settled[r_p_v]),
        .o_res     (relax)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state    = r_state;
        n_vcount   = r_vcount;
        n_root     = r_root;
        n_settled  = r_settled;
        n_p_vld    = 1'b0;
        n_o_valid  = r_o_valid;
        n_n_last   = r_n_last;
        n_v        = r_v;
        n_u        = r_u;
        n_p_v      = r_p_v;
        n_arg      = r_arg;
        n_best     = r_best;
        n_min      = r_min;
        n_o_vertex = r_o_vertex;
        n_o_dist   = r_o_dist;
        n_o_reach  = r_o_reach;
        n_o_last   = r_o_last;

        // Configuration writes.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: n_vcount = i_cfg_data;
                CFG_ROOT_VERTEX:  n_root   = i_cfg_data[VERTEX_BITS-1:0];
                default: ;
            endcase
        end

        // Track the least unsettled distance, lowest index first.
        if (r_p_vld && relax.candidate && (relax.distance < r_min)) begin
            n_min = relax.distance;
            n_arg = r_p_v;
        end

        case (r_state)
            S_LOAD: begin
                if (in_fire && i_item.last_entry) begin
                    n_n_last  = n_used_last[VW-1:0];
                    n_v       = '0;
                    n_settled = '0;
                    n_state   = S_INIT;
                end
            end
            S_INIT: begin
                if (r_v == r_n_last) begin
                    n_v = '0;
                    if (root_ok) begin
                        n_settled[root_idx] = 1'b1;
                        n_u     = root_idx;
                        n_best  = '0;
                        n_min   = DIST_INF;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_ORD;
                    end
                end else begin
                    n_v = r_v + VW'(1);
                end
            end
            S_SWEEP: begin
                n_p_vld = 1'b1;
                n_p_v   = r_v;
                if (r_v == r_n_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_v = r_v + VW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                n_v = '0;
                if (r_min != DIST_INF) begin
                    n_settled[r_arg] = 1'b1;
                    n_u     = r_arg;
                    n_best  = r_min;
                    n_min   = DIST_INF;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                n_state = S_OCAP;
            end
            S_OCAP: begin
                n_o_valid  = 1'b1;
                n_o_vertex = VERTEX_BITS'(r_v);
                n_o_dist   = r_drd;
                n_o_reach  = (r_drd != DIST_INF);
                n_o_last   = (r_v == r_n_last);
                n_state    = S_OWAIT;
            end
            S_OWAIT: begin
                if (o_result.ready) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_v     = r_v + VW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_vcount  <= VERTEX_COUNT_RST;
            r_root    <= ROOT_VERTEX_RST;
            r_settled <= '0;
            r_p_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vcount  <= n_vcount;
            r_root    <= n_root;
            r_settled <= n_settled;
            r_p_vld   <= n_p_vld;
            r_o_valid <= n_o_valid;
        end
        r_n_last   <= n_n_last;
        r_v        <= n_v;
        r_u        <= n_u;
        r_p_v      <= n_p_v;
        r_arg      <= n_arg;
        r_best     <= n_best;
        r_min      <= n_min;
        r_o_vertex <= n_o_vertex;
        r_o_dist   <= n_o_dist;
        r_o_reach  <= n_o_reach;
        r_o_last   <= n_o_last;
    end
endmodule

[design/dssp_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the dense shortest path block
// Watches the top-level ports and checks ordering of load and output phases, result stability and the reachable flag.
// ----------------------------------------------------------------------------
`include "dense_single_source_shortest_path_macros.svh"

module dssp_port_checker
    import dssp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_item_ready,
    input logic                   i_res_valid,
    input logic                   i_res_ready,
    input logic [VERTEX_BITS-1:0] i_res_vertex,
    input logic [DIST_BITS-1:0]   i_res_distance,
    input logic                   i_res_reachable,
    input logic                   i_res_last_result
);
    logic res_fire;

    assign res_fire = i_res_valid && i_res_ready;

    // Loading never overlaps a pending result.
    `DSSP_ASSERT_IMP(a_no_load_during_output, i_clk, i_rst_n, i_res_valid, !i_item_ready, "input ready while a result is pending")

    // A stalled result transaction holds its payload.
    `DSSP_ASSERT_NXT(a_result_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_vertex) && $stable(i_res_distance) && $stable(i_res_reachable) && $stable(i_res_last_result), "stalled result changed")

    // The reachable flag agrees with the distance.
    `DSSP_ASSERT_IMP(a_reachable_match, i_clk, i_rst_n, i_res_valid, i_res_reachable == (i_res_distance != DIST_INF), "reachable flag disagrees with distance")

    // More results follow before loading resumes.
    `DSSP_ASSERT_NXT(a_more_results, i_clk, i_rst_n, res_fire && !i_res_last_result, !i_item_ready && !i_res_valid, "loading resumed before the last result")

    // The final result returns the block to loading.
    `DSSP_ASSERT_NXT(a_back_to_load, i_clk, i_rst_n, res_fire && i_res_last_result, i_item_ready && !i_res_valid, "block not ready after the last result")
endmodule

bind dense_single_source_shortest_path dssp_port_checker u_dssp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_item_ready      (i_item.ready),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_res_vertex      (o_result.vertex),
    .i_res_distance    (o_result.distance),
    .i_res_reachable   (o_result.reachable),
    .i_res_last_result (o_result.last_result)
);

[test/dssp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shortest path result checker
// Watches the weight entry channel, the result channel and the register
// port, keeps its own copy of the weight matrix and registers, solves the
// shortest paths on every final entry and compares each result transaction
// field by field with the oldest distance still expected.
// ----------------------------------------------------------------------------
module dssp_checker
    import dssp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    dssp_in_if                        i_item,
    dssp_out_if                       i_result,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int NV = MAX_VERTICES_DEF;
    localparam logic [WEIGHT_IN_BITS-1:0] NO_EDGE = '1;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] vertex;
        logic [DIST_BITS-1:0]   distance;
        logic                   reachable;
        logic                   last_result;
    } t_dist_result;

    logic [WEIGHT_IN_BITS-1:0] weight_mem [NV][NV];
    logic [COUNT_BITS-1:0]     vertex_count;
    logic [VERTEX_BITS-1:0]    root_vertex;
    t_dist_result              expected_dist_q [$];
    int                        fail_total;

    // Solve from the root over the stored matrix and queue one distance per vertex.
    function automatic void solve_distances();
        int                   n;
        int                   u;
        int                   v;
        int                   round;
        bit                   stop;
        bit                   found;
        bit                   settled [NV];
        logic [DIST_BITS-1:0] tent [NV];
        logic [DIST_BITS-1:0] best;
        logic [DIST_BITS:0]   sum;
        t_dist_result         res;

        n = vertex_count;
        if (n == 0) n = 1;
        if (n > NV) n = NV;
        for (v = 0; v < NV; v++) begin
            settled[v] = 1'b0;
            tent[v]    = DIST_INF;
        end

        if (root_vertex < n) begin
            tent[root_vertex] = '0;
            stop = 1'b0;
            for (round = 0; round < n && !stop; round++) begin
                // Pick the closest unsettled vertex; the lowest index wins a tie.
                best  = DIST_INF;
                u     = 0;
                found = 1'b0;
                for (v = 0; v < n; v++) begin
                    if (!settled[v] && tent[v] < best) begin
                        best  = tent[v];
                        u     = v;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    stop = 1'b1;
                end else begin
                    settled[u] = 1'b1;
                    // Relax the unsettled neighbors with saturating sums.
                    for (v = 0; v < n; v++) begin
                        if (!settled[v] && weight_mem[u][v] != NO_EDGE) begin
                            sum = {1'b0, best} + weight_mem[u][v];
                            if (sum > DIST_INF) sum = DIST_INF;
                            if (sum[DIST_BITS-1:0] < tent[v]) tent[v] = sum[DIST_BITS-1:0];
                        end
                    end
                end
            end
        end

        for (v = 0; v < n; v++) begin
            res.vertex      = VERTEX_BITS'(v);
            res.distance    = tent[v];
            res.reachable   = (tent[v] != DIST_INF);
            res.last_result = (v == n - 1);
            expected_dist_q.push_back(res);
        end
    endfunction

    // Track register writes, check results and store weight entries.
    always @(posedge i_clk) begin
        t_dist_result exp_res;

        if (!i_rst_n) begin
            vertex_count = VERTEX_COUNT_RST;
            root_vertex  = ROOT_VERTEX_RST;
            expected_dist_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT: vertex_count = i_cfg_data[COUNT_BITS-1:0];
                    CFG_ROOT_VERTEX:  root_vertex = i_cfg_data[VERTEX_BITS-1:0];
                    default: ;
                endcase
            end

            // A result transaction is matched against the oldest expectation.
            if (i_result.valid && i_result.ready) begin
                if (expected_dist_q.size() == 0) begin
                    $display("%0t: result transaction with none expected, vertex %0d distance %0d",
                             $time, i_result.vertex, i_result.distance);
                    fail_total++;
                end else begin
                    exp_res = expected_dist_q.pop_front();
                    if (i_result.vertex !== exp_res.vertex) begin
                        $display("%0t: vertex mismatch, expected %0d, actual %0d",
                                 $time, exp_res.vertex, i_result.vertex);
                        fail_total++;
                    end
                    if (i_result.distance !== exp_res.distance) begin
                        $display("%0t: distance mismatch at vertex %0d, expected %0d, actual %0d",
                                 $time, exp_res.vertex, exp_res.distance, i_result.distance);
                        fail_total++;
                    end
                    if (i_result.reachable !== exp_res.reachable) begin
                        $display("%0t: reachable mismatch at vertex %0d, expected %0b, actual %0b",
                                 $time, exp_res.vertex, exp_res.reachable, i_result.reachable);
                        fail_total++;
                    end
                    if (i_result.last_result !== exp_res.last_result) begin
                        $display("%0t: last_result mismatch at vertex %0d, expected %0b, actual %0b",
                                 $time, exp_res.vertex, exp_res.last_result,
                                 i_result.last_result);
                        fail_total++;
                    end
                end
            end

            // Every entry is stored; the final one also starts a solve.
            if (i_item.valid && i_item.ready) begin
                weight_mem[i_item.row][i_item.column] = i_item.weight;
                if (i_item.last_entry) solve_distances();
            end
        end

        o_pending    <= expected_dist_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shortest path block testbench
// Loads weight matrices in bursts with random gaps, starts solves under
// several vertex counts and roots, stalls the result side on its own pattern
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import dssp_pkg::*;

    localparam int NV           = MAX_VERTICES_DEF;
    localparam int IDLE_LIMIT   = 25000;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [WEIGHT_IN_BITS-1:0] NO_EDGE = '1;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} t_stall_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending;
    int                        idle_cycles;

    // Stimulus-side view of the matrix, used only to keep reads on written entries.
    logic [WEIGHT_IN_BITS-1:0] load_w   [NV][NV];
    bit                        load_set [NV][NV];
    bit                        reach    [NV];
    int                        cur_n;
    int                        cur_root;
    int                        burst_left;
    int                        items_sent;

    dssp_in_if  item_ch ();
    dssp_out_if res_ch ();

    dense_single_source_shortest_path u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (res_ch)
    );

    dssp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .i_result    (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dense_single_source_shortest_path regression: fail");
            $finish;
        end
    end

    // Result side stalls in spans of no stall, random stall and heavy stall.
    initial begin
        t_stall_mode mode;
        int          span;

        res_ch.ready <= 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 2));
            span = $urandom_range(20, 300);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:   res_ch.ready <= 1'b1;
                    STALL_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
                    default:      res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic int used_count(input int count);
        if (count == 0) return 1;
        if (count > NV) return NV;
        return count;
    endfunction

    // Weights mix missing edges, zero, the largest edge, small and wide values.
    function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight(input int edge_pct);
        int sel;

        if ($urandom_range(0, 99) >= edge_pct) return NO_EDGE;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return NO_EDGE - 1'b1;
            2, 3, 4: return WEIGHT_IN_BITS'($urandom_range(1, 15));
            default: return WEIGHT_IN_BITS'($urandom_range(0, 16'hFFFE));
        endcase
    endfunction

    // Registers are written back to back while the block is idle.
    task automatic write_config(input int count, input int root);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data  <= CFG_DATA_BITS'(count);
        @(posedge i_clk);
        cfg_index <= CFG_ROOT_VERTEX;
        cfg_data  <= CFG_DATA_BITS'(root);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_n    = used_count(count);
        cur_root = root;
    endtask

    // One weight entry transaction, sent in bursts with random gaps between them.
    task automatic send_entry(input int row, input int col,
                              input logic [WEIGHT_IN_BITS-1:0] w, input bit last);
        int gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_ch.valid      <= 1'b1;
        item_ch.row        <= VERTEX_BITS'(row);
        item_ch.column     <= VERTEX_BITS'(col);
        item_ch.weight     <= w;
        item_ch.last_entry <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        burst_left--;
        load_w[row][col]   = w;
        load_set[row][col] = 1'b1;
        items_sent++;
    endtask

    // Vertices that a solve may settle: closure from the root over written edges.
    task automatic find_reach(output int reach_size);
        int u;
        int v;
        bit grown;

        for (v = 0; v < NV; v++) reach[v] = 1'b0;
        if (cur_root < cur_n) reach[cur_root] = 1'b1;
        do begin
            grown = 1'b0;
            for (u = 0; u < cur_n; u++) begin
                for (v = 0; v < cur_n; v++) begin
                    if (reach[u] && !reach[v] && load_set[u][v] && load_w[u][v] != NO_EDGE) begin
                        reach[v] = 1'b1;
                        grown    = 1'b1;
                    end
                end
            end
        end while (grown);
        reach_size = 0;
        for (v = 0; v < NV; v++) reach_size += reach[v];
    endtask

    // One matrix set: random noise entries, then every entry that a solve may
    // read, then a final entry that cannot widen the reachable set.
    task automatic send_set(input int noise, input int edge_pct, input int max_reach);
        int                        u;
        int                        v;
        int                        row;
        int                        col;
        int                        reach_size;
        bit                        missing;
        logic [WEIGHT_IN_BITS-1:0] w;

        repeat (noise) begin
            w = (cur_n > 16) ? NO_EDGE : pick_weight(edge_pct);
            send_entry($urandom_range(0, NV - 1), $urandom_range(0, NV - 1), w, 1'b0);
        end

        missing = 1'b1;
        while (missing) begin
            find_reach(reach_size);
            missing = 1'b0;
            for (u = 0; u < cur_n && !missing; u++) begin
                for (v = 0; v < cur_n && !missing; v++) begin
                    if (reach[u] && !load_set[u][v]) begin
                        missing = 1'b1;
                        row     = u;
                        col     = v;
                    end
                end
            end
            if (missing) begin
                w = (reach_size >= max_reach) ? NO_EDGE : pick_weight(edge_pct);
                send_entry(row, col, w, 1'b0);
            end
        end

        row = $urandom_range(0, NV - 1);
        col = $urandom_range(0, NV - 1);
        w   = pick_weight(edge_pct);
        if (reach[row] && col < cur_n && !reach[col]) w = NO_EDGE;
        send_entry(row, col, w, 1'b1);
    endtask

    // Hold the sender until every expected distance has come, then let the block settle.
    task automatic wait_results_done();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Stimulus and verdict.
    initial begin
        int count;
        int root;
        int big_root;
        int sel;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_VERTEX_COUNT;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.row        <= '0;
        item_ch.column     <= '0;
        item_ch.weight     <= '0;
        item_ch.last_entry <= 1'b0;
        burst_left         = 0;
        items_sent         = 0;
        cur_n              = NV;
        cur_root           = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single vertex: the root alone, at distance zero.
        write_config(1, 0);
        send_entry(0, 0, NO_EDGE, 1'b1);
        wait_results_done();

        // Three vertices from root 2: a tie between 0 and 1, zero and largest weights.
        write_config(3, 2);
        send_entry(2, 0, 16'd5, 1'b0);
        send_entry(2, 1, 16'd5, 1'b0);
        send_entry(2, 2, 16'd0, 1'b0);
        send_entry(0, 0, NO_EDGE, 1'b0);
        send_entry(0, 1, 16'd0, 1'b0);
        send_entry(0, 2, 16'd1, 1'b0);
        send_entry(1, 0, NO_EDGE - 1'b1, 1'b0);
        send_entry(1, 1, 16'd7, 1'b0);
        send_entry(1, 2, NO_EDGE, 1'b1);
        wait_results_done();

        // Root beyond the vertex count: nothing is reachable.
        write_config(3, 63);
        send_entry(63, 63, 16'h0000, 1'b1);
        wait_results_done();

        // A vertex count of zero behaves as one vertex.
        write_config(0, 0);
        send_entry(0, 63, 16'h8001, 1'b1);
        wait_results_done();

        // Root with no way out leaves the other vertex unreachable.
        write_config(2, 1);
        send_entry(1, 0, NO_EDGE, 1'b0);
        send_entry(1, 1, 16'h7FFF, 1'b1);
        wait_results_done();

        // Full size, then an oversized count on the same root.
        items_sent = 0;
        big_root   = $urandom_range(0, NV - 1);
        write_config(64, big_root);
        send_set(2, 5, 2);
        wait_results_done();
        write_config(127, big_root);
        send_set(3, 5, 2);
        send_set(0, 5, 2);
        wait_results_done();

        // Mostly small graphs, one to four sets back to back per setting.
        while (items_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) count = 0;
            else if (sel <= 3) count = $urandom_range(7, 12);
            else count = $urandom_range(1, 6);
            if ($urandom_range(0, 4) == 0) root = $urandom_range(0, NV - 1);
            else root = $urandom_range(0, used_count(count) - 1);
            write_config(count, root);
            repeat ($urandom_range(1, 4)) begin
                send_set($urandom_range(0, 4), $urandom_range(30, 90), NV);
            end
            wait_results_done();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("dense_single_source_shortest_path regression: pass");
        end else begin
            $display("dense_single_source_shortest_path regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/dssp_pkg.sv
design/dssp_in_if.sv
design/dssp_out_if.sv
design/dssp_relax.sv
design/dense_single_source_shortest_path.sv
design/dssp_checker.sv
test/dssp_checker.sv
test/tb_top.sv
